// ----- hdl/swqm_pkg.sv -----
package swqm_pkg;

	localparam int MaxProcsDef = 20;
	localparam int AddrBitsDef = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_OUT    = 2'd2,
		ACT_HEAD   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_DESC = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RD_DESC,
		S_COMMIT,
		S_WALK,
		S_WALK_CHK,
		S_DONE
	} state_t;

endpackage

// ----- hdl/semaphore_wait_queue_manager_core.sv -----
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, action, sem_addr, proc_in
// out     | output    | out_valid, out_stall, status, proc_valid, proc_out
//
// One item at a time. Insert/remove/head: accept, scan over all MAX_PROCS
// descriptors (S_SCAN), decide, result.
// Out: accept, read descriptor, commit, result when the process is at the head
// or not found; else walk steps over the link table (S_WALK, S_WALK_CHK), up to
// MAX_PROCS steps. The scan compares one descriptor per step.
// Reset clears used/blocked bits at once; no clearing pass.
// in_stall stays high from acceptance until the result is taken; out_stall
// holds the result in S_DONE while it waits.
module semaphore_wait_queue_manager_core #(
	parameter int MAX_PROCS = swqm_pkg::MaxProcsDef,
	parameter int ADDR_BITS = swqm_pkg::AddrBitsDef,
	localparam int IW = $clog2(MAX_PROCS)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] sem_addr,
	input  logic [4:0]  proc_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        proc_valid,
	output logic [4:0]  proc_out
);

	// descriptor and process tables (small, register arrays)
	logic [ADDR_BITS-1:0] desc_key_q [MAX_PROCS];
	logic [IW-1:0]        desc_head_q [MAX_PROCS];
	logic [IW-1:0]        desc_tail_q [MAX_PROCS];
	logic [IW-1:0]        proc_link_q [MAX_PROCS];
	logic [IW-1:0]        proc_desc_q [MAX_PROCS];
	logic [MAX_PROCS-1:0] desc_used_q;
	logic [MAX_PROCS-1:0] proc_blocked_q;

	swqm_pkg::state_t state_q, state_d;
	swqm_pkg::action_t act_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [4:0] p_q;
	logic p_ok;
	logic [IW-1:0] pi, d_q, t_q, prev_q, cnt_q;
	logic [1:0] st_q;
	logic pv_q;
	logic [4:0] po_q;
	logic ovalid_q;

	assign p_ok = (int'(p_q) < MAX_PROCS);
	assign pi = IW'(p_q);

	logic [IW-1:0] s_idx, s_hit_idx, s_free_idx;
	logic s_last, s_hit, s_free, s_start, s_step;
	assign s_start = (state_q == swqm_pkg::S_IDLE);
	assign s_step = (state_q == swqm_pkg::S_SCAN);

	swqm_scan #(.MAX_PROCS(MAX_PROCS), .ADDR_BITS(ADDR_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(s_start), .step(s_step),
		.key(key_q), .ent_key(desc_key_q[s_idx]), .ent_used(desc_used_q[s_idx]),
		.idx(s_idx), .last(s_last), .hit_q(s_hit), .hit_idx_q(s_hit_idx),
		.free_q(s_free), .free_idx_q(s_free_idx)
	);

	// result is offered only from S_DONE
	assign in_stall = (state_q != swqm_pkg::S_IDLE);
	assign out_valid = (state_q == swqm_pkg::S_DONE);
	assign status = st_q;
	assign proc_valid = pv_q;
	assign proc_out = po_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swqm_pkg::S_IDLE: if (in_valid) begin
				state_d = (swqm_pkg::action_t'(action) == swqm_pkg::ACT_OUT) ?
					swqm_pkg::S_RD_DESC : swqm_pkg::S_SCAN;
			end
			swqm_pkg::S_SCAN: if (s_last) state_d = swqm_pkg::S_DECIDE;
			swqm_pkg::S_DECIDE: state_d = swqm_pkg::S_DONE;
			swqm_pkg::S_RD_DESC: state_d = swqm_pkg::S_COMMIT;
			// done when not found or when the target sits at the head
			swqm_pkg::S_COMMIT: state_d = (ovalid_q || desc_head_q[d_q] == pi) ?
				swqm_pkg::S_DONE : swqm_pkg::S_WALK;
			swqm_pkg::S_WALK: state_d = swqm_pkg::S_WALK_CHK;
			swqm_pkg::S_WALK_CHK: state_d = ovalid_q ? swqm_pkg::S_DONE : swqm_pkg::S_WALK;
			swqm_pkg::S_DONE: if (!out_stall) state_d = swqm_pkg::S_IDLE;
			default: state_d = swqm_pkg::S_IDLE;
		endcase
	end

	// datapath; ovalid_q is raised when the result is settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swqm_pkg::S_IDLE;
			desc_used_q <= '0;
			proc_blocked_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				swqm_pkg::S_IDLE: if (in_valid) begin
					act_q <= swqm_pkg::action_t'(action);
					key_q <= ADDR_BITS'(sem_addr);
					p_q <= proc_in;
					st_q <= swqm_pkg::ST_MISSING;
					pv_q <= 1'b0;
					po_q <= '0;
				end
				swqm_pkg::S_SCAN: ;
				swqm_pkg::S_DECIDE: begin
					ovalid_q <= 1'b1;
					if (act_q == swqm_pkg::ACT_INSERT) begin
						if (p_ok && !proc_blocked_q[pi]) begin
							if (s_hit) begin
								proc_link_q[desc_tail_q[s_hit_idx]] <= pi;
								desc_tail_q[s_hit_idx] <= pi;
								proc_link_q[pi] <= pi;
								proc_desc_q[pi] <= s_hit_idx;
								proc_blocked_q[pi] <= 1'b1;
								st_q <= swqm_pkg::ST_OK;
							end else if (s_free) begin
								desc_used_q[s_free_idx] <= 1'b1;
								desc_key_q[s_free_idx] <= key_q;
								desc_head_q[s_free_idx] <= pi;
								desc_tail_q[s_free_idx] <= pi;
								proc_link_q[pi] <= pi;
								proc_desc_q[pi] <= s_free_idx;
								proc_blocked_q[pi] <= 1'b1;
								st_q <= swqm_pkg::ST_OK;
							end else begin
								st_q <= swqm_pkg::ST_NO_DESC;
							end
						end
					end else if (s_hit) begin
						st_q <= swqm_pkg::ST_OK;
						pv_q <= 1'b1;
						po_q <= 5'(desc_head_q[s_hit_idx]);
						if (act_q == swqm_pkg::ACT_REMOVE) begin
							proc_blocked_q[desc_head_q[s_hit_idx]] <= 1'b0;
							if (desc_tail_q[s_hit_idx] == desc_head_q[s_hit_idx])
								desc_used_q[s_hit_idx] <= 1'b0;
							else
								desc_head_q[s_hit_idx] <= proc_link_q[desc_head_q[s_hit_idx]];
						end
					end
				end
				swqm_pkg::S_RD_DESC: begin
					if (!(p_ok && proc_blocked_q[pi])) ovalid_q <= 1'b1;
					else begin
						d_q <= proc_desc_q[pi];
						if (!desc_used_q[proc_desc_q[pi]]) ovalid_q <= 1'b1;
					end
				end
				swqm_pkg::S_COMMIT: if (!ovalid_q) begin
					t_q <= desc_tail_q[d_q];
					prev_q <= desc_head_q[d_q];
					cnt_q <= '0;
					if (desc_head_q[d_q] == pi) begin
						if (desc_tail_q[d_q] == pi) desc_used_q[d_q] <= 1'b0;
						else desc_head_q[d_q] <= proc_link_q[pi];
						proc_blocked_q[pi] <= 1'b0;
						st_q <= swqm_pkg::ST_OK;
						pv_q <= 1'b1;
						po_q <= p_q;
						ovalid_q <= 1'b1;
					end
				end
				swqm_pkg::S_WALK: begin
					// one link read: is next of prev the target?
					if (proc_link_q[prev_q] == pi) begin
						if (t_q == pi) desc_tail_q[d_q] <= prev_q;
						else proc_link_q[prev_q] <= proc_link_q[pi];
						proc_blocked_q[pi] <= 1'b0;
						st_q <= swqm_pkg::ST_OK;
						pv_q <= 1'b1;
						po_q <= p_q;
						ovalid_q <= 1'b1;
					end else if (prev_q == t_q || cnt_q == IW'(MAX_PROCS - 1)) begin
						ovalid_q <= 1'b1;
					end else begin
						prev_q <= proc_link_q[prev_q];
					end
				end
				swqm_pkg::S_WALK_CHK: cnt_q <= cnt_q + IW'(1);
				swqm_pkg::S_DONE: if (!out_stall) ovalid_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/swqm_scan.sv -----
// Descriptor scan unit: one entry per cycle, finds key match and first free slot.
module swqm_scan #(
	parameter int MAX_PROCS = swqm_pkg::MaxProcsDef,
	parameter int ADDR_BITS = swqm_pkg::AddrBitsDef,
	localparam int IW = $clog2(MAX_PROCS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 step,
	input  logic [ADDR_BITS-1:0] key,
	input  logic [ADDR_BITS-1:0] ent_key,
	input  logic                 ent_used,
	output logic [IW-1:0]        idx,
	output logic                 last,
	output logic                 hit_q,
	output logic [IW-1:0]        hit_idx_q,
	output logic                 free_q,
	output logic [IW-1:0]        free_idx_q
);

	assign last = (idx == IW'(MAX_PROCS - 1));

	logic [IW-1:0] idx_q;
	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else if (start) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (step) begin
			if (!last) idx_q <= idx_q + IW'(1);
			if (ent_used && ent_key == key && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!ent_used && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
	end

endmodule

// ----- tb/semaphore_wait_queue_manager_core_test.sv -----
module semaphore_wait_queue_manager_core_test;

	localparam int NPROC = swqm_pkg::MaxProcsDef;

	typedef struct packed {
		swqm_pkg::status_t st;
		logic              pv;
		logic [4:0]        pid;
	} sem_result_t;

	// Scoreboard: shadow copy of the semaphore table plus queue of pending results.
	class sem_table_sb;
		logic [31:0] key  [NPROC];
		bit          used [NPROC];
		int          head [NPROC];
		int          tail [NPROC];
		int          link [NPROC];
		int          pdesc[NPROC];
		bit          blk  [NPROC];
		sem_result_t pending[$];
		int          errors;

		function void clear();
			for (int i = 0; i < NPROC; i++) begin
				used[i] = 0;
				blk[i] = 0;
			end
			pending.delete();
			errors = 0;
		endfunction

		function int lookup(logic [31:0] a);
			for (int d = 0; d < NPROC; d++)
				if (used[d] && key[d] == a) return d;
			return -1;
		endfunction

		function void note_request(swqm_pkg::action_t act, logic [31:0] a, logic [4:0] p);
			sem_result_t r;
			int d, h, prev, cur;
			r = '{swqm_pkg::ST_MISSING, 1'b0, 5'd0};
			case (act)
				swqm_pkg::ACT_INSERT: begin
					if (p < NPROC && !blk[p]) begin
						d = lookup(a);
						if (d < 0) begin
							for (int i = NPROC - 1; i >= 0; i--)
								if (!used[i]) d = i;
							if (d < 0) r.st = swqm_pkg::ST_NO_DESC;
							else begin
								used[d] = 1;
								key[d] = a;
								head[d] = p;
								tail[d] = p;
								r.st = swqm_pkg::ST_OK;
							end
						end else begin
							link[tail[d]] = p;
							tail[d] = p;
							r.st = swqm_pkg::ST_OK;
						end
						if (r.st == swqm_pkg::ST_OK) begin
							link[p] = p;
							pdesc[p] = d;
							blk[p] = 1;
						end
					end
				end
				swqm_pkg::ACT_REMOVE, swqm_pkg::ACT_HEAD: begin
					d = lookup(a);
					if (d >= 0) begin
						h = head[d];
						r = '{swqm_pkg::ST_OK, 1'b1, 5'(h)};
						if (act == swqm_pkg::ACT_REMOVE) begin
							blk[h] = 0;
							if (tail[d] == h) used[d] = 0;
							else head[d] = link[h];
						end
					end
				end
				default: begin
					if (p < NPROC && blk[p]) begin
						d = pdesc[p];
						if (used[d]) begin
							if (head[d] == p) begin
								if (tail[d] == p) used[d] = 0;
								else head[d] = link[p];
								r.st = swqm_pkg::ST_OK;
							end else begin
								prev = head[d];
								for (int i = 0; i < NPROC; i++) begin
									cur = link[prev];
									if (cur == p) begin
										if (tail[d] == p) tail[d] = prev;
										else link[prev] = link[p];
										r.st = swqm_pkg::ST_OK;
										break;
									end
									if (prev == tail[d]) break;
									prev = cur;
								end
							end
							if (r.st == swqm_pkg::ST_OK) blk[p] = 0;
						end
					end
					if (r.st == swqm_pkg::ST_OK) begin
						r.pv = 1;
						r.pid = p;
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(swqm_pkg::status_t st, logic pv, logic [4:0] pid);
			sem_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status=%0d", st);
				return;
			end
			e = pending.pop_front();
			if (e.st !== st || e.pv !== pv || e.pid !== pid) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st=%0d pv=%0d pid=%0d, got st=%0d pv=%0d pid=%0d",
						e.st, e.pv, e.pid, st, pv, pid);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  action = 0;
	logic [31:0] sem_addr = 0;
	logic [4:0]  proc_in = 0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [1:0]  status;
	logic        proc_valid;
	logic [4:0]  proc_out;

	sem_table_sb sb;
	int          idle_cycles = 0;
	int          out_wait = 0;
	logic [31:0] addr_pool[6];

	semaphore_wait_queue_manager_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Sender: draw a random gap with in_valid low, then hold the item until taken.
	task automatic send_item(swqm_pkg::action_t act, logic [31:0] a, logic [4:0] p);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		sem_addr <= a;
		proc_in <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(act, a, p);
		@(negedge clk);
	endtask

	// Receiver: stall drawn at random per item; sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(swqm_pkg::status_t'(status), proc_valid, proc_out);
			out_wait = $urandom_range(0, 4);
		end else if (out_wait > 0)
			out_wait--;
	end
	always @(negedge clk) begin
		out_stall <= (out_wait > 0);
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return addr_pool[$urandom_range(0, 5)];
	endfunction

	initial begin
		int r;
		sb = new();
		sb.clear();
		addr_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'h0000_0001, 32'h5555_AAAA};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty queue lookups, bad pids, fill every descriptor then empty them.
		send_item(swqm_pkg::ACT_REMOVE, 32'h0, 5'd0);
		send_item(swqm_pkg::ACT_HEAD, 32'hFFFF_FFFF, 5'd0);
		send_item(swqm_pkg::ACT_OUT, 32'h0, 5'd3);
		send_item(swqm_pkg::ACT_INSERT, 32'h0, 5'd31);
		send_item(swqm_pkg::ACT_OUT, 32'h0, 5'd20);
		send_item(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
		send_item(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd0);   // already blocked
		send_item(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd19);
		send_item(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd7);
		send_item(swqm_pkg::ACT_OUT, 32'h0, 5'd19);             // middle of queue
		send_item(swqm_pkg::ACT_OUT, 32'h0, 5'd7);              // tail
		send_item(swqm_pkg::ACT_HEAD, 32'hFFFF_FFFF, 5'd0);
		send_item(swqm_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 5'd0);   // releases descriptor
		// one process per address: all 20 descriptors busy, no more processes though
		for (int i = 0; i < NPROC; i++)
			send_item(swqm_pkg::ACT_INSERT, 32'(i * 3 + 1), 5'(i));
		for (int i = 0; i < NPROC; i++) send_item(swqm_pkg::ACT_OUT, 32'h0, 5'(i));

		// Random: mostly small address pool to build deep queues.
		for (int n = 0; n < 600; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_item(swqm_pkg::ACT_INSERT, pick_addr(), 5'($urandom_range(0, 21)));
			else if (r < 62)
				send_item(swqm_pkg::ACT_REMOVE, pick_addr(), 5'($urandom));
			else if (r < 82)
				send_item(swqm_pkg::ACT_OUT, $urandom, 5'($urandom_range(0, 19) |
					($urandom_range(0, 15) == 0 ? 5'h1F : 5'h0)));
			else
				send_item(swqm_pkg::ACT_HEAD, pick_addr(), 5'($urandom));
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
